### rtl/core/mm3_pkg.sv
// Package: shared constants, command and status types, and helper functions for the MurmurHash3 block.
`timescale 1ns / 1ps
package mm3_pkg;

  localparam logic [31:0] MM_C1 = 32'hcc9e2d51;
  localparam logic [31:0] MM_C2 = 32'h1b873593;
  localparam logic [31:0] MM_N  = 32'he6546b64;
  localparam logic [31:0] MM_F1 = 32'h85ebca6b;
  localparam logic [31:0] MM_F2 = 32'hc2b2ae35;

  localparam logic [2:0] FULL_COUNT = 3'd4;

  // Controller to datapath commands, one step per cycle at most.
  typedef struct packed {
    logic load_in;   // capture request word, count and last flag
    logic mul1;      // word times C1
    logic mul2;      // rotate 15, times C2
    logic fold;      // fold scrambled word into accumulator
    logic fin1;      // first finalizer multiply
    logic fin2;      // second finalizer multiply
    logic out_load;  // load final hash into output register
  } mm3_cmd_t;

  typedef struct packed {
    logic last;      // captured request ends the message
  } mm3_status_t;

  function automatic logic [31:0] rotl15(input logic [31:0] v);
    rotl15 = {v[16:0], v[31:17]};
  endfunction

  function automatic logic [31:0] rotl13(input logic [31:0] v);
    rotl13 = {v[18:0], v[31:19]};
  endfunction

  // Keep the low bytes named by the count; counts of four or more keep all.
  function automatic logic [31:0] byte_mask(input logic [2:0] cnt);
    logic [31:0] m;
    m = '1;
    case (cnt)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'h0000_00ff;
      3'd2:    m = 32'h0000_ffff;
      3'd3:    m = 32'h00ff_ffff;
      default: m = 32'hffff_ffff;
    endcase
    byte_mask = m;
  endfunction

endpackage

### rtl/core/murmur3_32_stream_hash.sv
// Top level: MurmurHash3 x86_32 over a stream of little-endian 32-bit words.
// A request is taken only while the controller is idle; each word is loaded, multiplied twice
//   and folded; a final word then runs two finalizer multiplies and waits out any output stall;
//   the steps are serial because of the one shared 32x32 multiplier, which serves four steps in turn.
// Reset (rst_n, synchronous, active low): seed and accumulator go to 0, length to 0,
//   controller to idle and the output register empty.
`timescale 1ns / 1ps
module murmur3_32_stream_hash (
  input  logic        clk,
  input  logic        rst_n,
  // Seed register: a write also restarts the message from the new seed.
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  // Input request channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_last_word,
  // Result channel, one request per finished message.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_hash_value
);
  import mm3_pkg::*;

  mm3_cmd_t    cmd;
  mm3_status_t status;

  // Controller: hold new requests while one is in work; the output register
  // lets the next message start while a finished hash still waits.
  mm3_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: mask the tail bytes on capture, scramble with two multiplies,
  // fold into the accumulator, mix in the length and run the finalizer.
  mm3_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_data_word   (in_data_word),
    .in_byte_count  (in_byte_count),
    .in_last_word   (in_last_word),
    .out_hash_value (out_hash_value),
    .cmd            (cmd),
    .status         (status)
  );

endmodule

### rtl/core/mm3_ctrl.sv
// Controller: sequences one request through scramble, fold and finalize steps.
`timescale 1ns / 1ps
module mm3_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  mm3_pkg::mm3_status_t status,
  output mm3_pkg::mm3_cmd_t    cmd
);
  import mm3_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_FOLD,
    S_FIN1,
    S_FIN2,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_FOLD;
      end
      S_FOLD: begin
        cmd.fold  = 1'b1;
        state_nxt = status.last ? S_FIN1 : S_IDLE;
      end
      S_FIN1: begin
        cmd.fin1  = 1'b1;
        state_nxt = S_FIN2;
      end
      S_FIN2: begin
        cmd.fin2  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/core/mm3_dpath.sv
// Datapath: seed, accumulator, length, shared multiplier and output register.
`timescale 1ns / 1ps
module mm3_dpath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [31:0]          cfg_wr_data,
  input  logic [31:0]          in_data_word,
  input  logic [2:0]           in_byte_count,
  input  logic                 in_last_word,
  output logic [31:0]          out_hash_value,
  input  mm3_pkg::mm3_cmd_t    cmd,
  output mm3_pkg::mm3_status_t status
);
  import mm3_pkg::*;

  logic [31:0] seed_r, acc_r, len_r;
  logic [31:0] w_r, f_r, hash_r;
  logic [2:0]  cnt_r, cnt_in;
  logic        last_r;
  logic [31:0] mul_a, mul_b, product;
  logic [31:0] mix, blk, h_new, len_new, f_pre;

  // Non-final words always count four; saturate anything above four.
  always_comb begin
    cnt_in = in_byte_count;
    if (!in_last_word || in_byte_count > FULL_COUNT) begin
      cnt_in = FULL_COUNT;
    end
  end

  // One multiplier shared by the four multiply steps.
  always_comb begin
    mul_a = w_r;
    mul_b = MM_C1;
    if (cmd.mul2) begin
      mul_a = rotl15(w_r);
      mul_b = MM_C2;
    end else if (cmd.fin1) begin
      mul_a = f_r ^ (f_r >> 16);
      mul_b = MM_F1;
    end else if (cmd.fin2) begin
      mul_a = f_r ^ (f_r >> 13);
      mul_b = MM_F2;
    end
  end
  assign product = mul_a * mul_b;

  // Full block: rotate 13, times five, add offset. Tail: plain xor.
  assign mix     = rotl13(acc_r ^ w_r);
  assign blk     = mix + {mix[29:0], 2'b00} + MM_N;
  assign h_new   = (cnt_r == FULL_COUNT) ? blk : (acc_r ^ w_r);
  assign len_new = len_r + {29'd0, cnt_r};
  assign f_pre   = h_new ^ len_new;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
      acc_r  <= '0;
      len_r  <= '0;
    end else if (cfg_wr_en) begin
      seed_r <= cfg_wr_data;
      acc_r  <= cfg_wr_data;
      len_r  <= '0;
    end else if (cmd.fold) begin
      if (last_r) begin
        acc_r <= seed_r;
        len_r <= '0;
      end else begin
        acc_r <= h_new;
        len_r <= len_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      w_r    <= in_data_word & byte_mask(cnt_in);
      cnt_r  <= cnt_in;
      last_r <= in_last_word;
    end else if (cmd.mul1 || cmd.mul2) begin
      w_r <= product;
    end
    if (cmd.fold) begin
      f_r <= f_pre;
    end else if (cmd.fin1 || cmd.fin2) begin
      f_r <= product;
    end
    if (cmd.out_load) begin
      hash_r <= f_r ^ (f_r >> 16);
    end
  end

  assign status.last    = last_r;
  assign out_hash_value = hash_r;

endmodule
